// File: sv/aat_pkg.sv
package aat_pkg;

  localparam int W             = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int N_CELLS       = 8;
  localparam int DIM           = 4;
  localparam int PROD_W        = 2 * W;
  localparam int SUM_W         = PROD_W + 2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_BOX  = 1'b1;

  typedef logic signed [W-1:0] word_t;
  typedef word_t [DIM*DIM-1:0] mat_t;
  typedef word_t [DIM-1:0] vec4_t;

  typedef struct packed {
    word_t lo_x;
    word_t lo_y;
    word_t lo_z;
    word_t hi_x;
    word_t hi_y;
    word_t hi_z;
  } box_t;

  // token travelling down the cell row
  typedef struct packed {
    logic  valid;
    box_t  box;
    mat_t  mat;
    vec4_t lo;
    vec4_t hi;
  } tok_t;

endpackage

// File: sv/aat_ifs.sv
interface aat_item_if;
  import aat_pkg::*;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  row_index;
  word_t       row_col0;
  word_t       row_col1;
  word_t       row_col2;
  word_t       row_col3;
  word_t       lo_x;
  word_t       lo_y;
  word_t       lo_z;
  word_t       hi_x;
  word_t       hi_y;
  word_t       hi_z;
  modport source (output valid, mode, row_index, row_col0, row_col1, row_col2, row_col3,
                  lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, input ready);
  modport sink   (input valid, mode, row_index, row_col0, row_col1, row_col2, row_col3,
                  lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, output ready);
endinterface

interface aat_result_if;
  import aat_pkg::*;
  logic  valid;
  logic  ready;
  word_t out_lo_x;
  word_t out_lo_y;
  word_t out_lo_z;
  word_t out_lo_w;
  word_t out_hi_x;
  word_t out_hi_y;
  word_t out_hi_z;
  word_t out_hi_w;
  modport source (output valid, out_lo_x, out_lo_y, out_lo_z, out_lo_w,
                  out_hi_x, out_hi_y, out_hi_z, out_hi_w, input ready);
  modport sink   (input valid, out_lo_x, out_lo_y, out_lo_z, out_lo_w,
                  out_hi_x, out_hi_y, out_hi_z, out_hi_w, output ready);
endinterface

interface aat_cfg_if;
  import aat_pkg::*;
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: sv/aat_cell.sv
module aat_cell #(
  parameter int CORNER    = 0,
  parameter int FRAC_BITS = aat_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  aat_pkg::word_t w,
  input  aat_pkg::tok_t din,
  output aat_pkg::tok_t dout
);
  import aat_pkg::*;

  localparam logic [2:0] CSEL = 3'(CORNER);
  localparam logic signed [SUM_W-1:0] SMAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SMIN = -SUM_W'(64'sd2147483648);

  vec4_t v;
  logic signed [PROD_W-1:0] prod [DIM][DIM];
  tok_t  tok1, tok2, tok3;
  vec4_t t2;

  assign v[0] = CSEL[2] ? din.box.hi_x : din.box.lo_x;
  assign v[1] = CSEL[1] ? din.box.hi_y : din.box.lo_y;
  assign v[2] = CSEL[0] ? din.box.hi_z : din.box.lo_z;
  assign v[3] = w;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      tok1.valid <= 1'b0;
    end else if (en) begin
      tok1.valid <= din.valid;
    end
    if (en) begin
      tok1.box <= din.box;
      tok1.mat <= din.mat;
      tok1.lo  <= din.lo;
      tok1.hi  <= din.hi;
      for (int i = 0; i < DIM; i++) begin
        for (int j = 0; j < DIM; j++) begin
          prod[i][j] <= PROD_W'(v[i]) * PROD_W'(din.mat[i*DIM+j]);
        end
      end
    end
  end

  // stage 2: column sums, scale, saturate
  always_ff @(posedge clk) begin
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] sh;
    if (rst) begin
      tok2.valid <= 1'b0;
    end else if (en) begin
      tok2.valid <= tok1.valid;
    end
    if (en) begin
      tok2.box <= tok1.box;
      tok2.mat <= tok1.mat;
      tok2.lo  <= tok1.lo;
      tok2.hi  <= tok1.hi;
      for (int j = 0; j < DIM; j++) begin
        s = SUM_W'(prod[0][j]) + SUM_W'(prod[1][j]) + SUM_W'(prod[2][j]) + SUM_W'(prod[3][j]);
        sh = s >>> FRAC_BITS;
        if (sh > SMAX) begin
          t2[j] <= word_t'(SMAX[W-1:0]);
        end else if (sh < SMIN) begin
          t2[j] <= word_t'(SMIN[W-1:0]);
        end else begin
          t2[j] <= sh[W-1:0];
        end
      end
    end
  end

  // stage 3: fold into running bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      tok3.valid <= 1'b0;
    end else if (en) begin
      tok3.valid <= tok2.valid;
    end
    if (en) begin
      tok3.box <= tok2.box;
      tok3.mat <= tok2.mat;
      for (int j = 0; j < DIM; j++) begin
        tok3.lo[j] <= (CORNER == 0 || t2[j] < tok2.lo[j]) ? t2[j] : tok2.lo[j];
        tok3.hi[j] <= (CORNER == 0 || t2[j] > tok2.hi[j]) ? t2[j] : tok2.hi[j];
      end
    end
  end

  assign dout = tok3;

endmodule

// File: sv/aabb_affine_transform_top.sv
// Path from item word to result word: 8 cells of 3 stages, the first loaded at acceptance, then
// the output register. Throughput: one item per cycle unless a waiting result stalls the row;
// each cell folds in one corner of the box passing through it.
// Load words update the matrix at once and give no result.
// Reset (rst, synchronous): matrix to identity, corner_w to 1.0, pipeline and output emptied.
// The row keeps filling while a result word waits, until its last stage holds a result.
module aabb_affine_transform_top #(
  parameter int FRAC_BITS = aat_pkg::FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  aat_item_if.sink    item,
  aat_cfg_if.sink     cfg,
  aat_result_if.source result
);
  import aat_pkg::*;

  localparam word_t ONE = word_t'(64'sd1 <<< FRAC_BITS);

  mat_t  mat;
  word_t corner_w;
  tok_t  chain [N_CELLS+1];
  logic  en;
  logic  acc;
  logic  res_valid;
  vec4_t res_lo, res_hi;

  assign en         = !chain[N_CELLS].valid || !res_valid || result.ready;
  assign item.ready = en;
  assign acc        = item.valid && en;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_w <= ONE;
      for (int k = 0; k < DIM*DIM; k++) begin
        mat[k] <= (k % (DIM + 1) == 0) ? ONE : '0;
      end
    end else begin
      if (cfg.valid) begin
        corner_w <= cfg.data;
      end
      if (acc && item.mode == MODE_LOAD) begin
        mat[{item.row_index, 2'd0}] <= item.row_col0;
        mat[{item.row_index, 2'd1}] <= item.row_col1;
        mat[{item.row_index, 2'd2}] <= item.row_col2;
        mat[{item.row_index, 2'd3}] <= item.row_col3;
      end
    end
  end

  always_comb begin
    chain[0].valid    = acc && item.mode == MODE_BOX;
    chain[0].box.lo_x = item.lo_x;
    chain[0].box.lo_y = item.lo_y;
    chain[0].box.lo_z = item.lo_z;
    chain[0].box.hi_x = item.hi_x;
    chain[0].box.hi_y = item.hi_y;
    chain[0].box.hi_z = item.hi_z;
    chain[0].mat      = mat;
    chain[0].lo       = '0;
    chain[0].hi       = '0;
  end

  for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
    aat_cell #(.CORNER(c), .FRAC_BITS(FRAC_BITS)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .w    (corner_w),
      .din  (chain[c]),
      .dout (chain[c+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      if (chain[N_CELLS].valid) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
    if (en && chain[N_CELLS].valid) begin
      res_lo <= chain[N_CELLS].lo;
      res_hi <= chain[N_CELLS].hi;
    end
  end

  assign result.valid    = res_valid;
  assign result.out_lo_x = res_lo[0];
  assign result.out_lo_y = res_lo[1];
  assign result.out_lo_z = res_lo[2];
  assign result.out_lo_w = res_lo[3];
  assign result.out_hi_x = res_hi[0];
  assign result.out_hi_y = res_hi[1];
  assign result.out_hi_z = res_hi[2];
  assign result.out_hi_w = res_hi[3];

endmodule

// File: test/aabb_affine_transform_top_tb.sv
module aabb_affine_transform_top_tb;
  import aat_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int LATENCY   = 24;
  localparam int MAX_CYCLE = 400000;

  typedef struct {
    word_t lo_x, lo_y, lo_z, lo_w, hi_x, hi_y, hi_z, hi_w;
  } bounds_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aat_item_if   item_ch();
  aat_cfg_if    cfg_ch();
  aat_result_if res_ch();

  aabb_affine_transform_top dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch.sink),
    .cfg   (cfg_ch.sink),
    .result(res_ch.source)
  );

  always #1 clk = ~clk;

  word_t   model_mat [DIM*DIM];
  word_t   model_w;
  bounds_t bounds_q [$];
  int      err_count   = 0;
  int      box_count   = 0;
  int      load_count  = 0;
  int      got_count   = 0;
  longint  cycle_count = 0;

  initial begin
    item_ch.valid = 1'b0;
    item_ch.mode = MODE_LOAD;
    item_ch.row_index = '0;
    {item_ch.row_col0, item_ch.row_col1, item_ch.row_col2, item_ch.row_col3} = '0;
    {item_ch.lo_x, item_ch.lo_y, item_ch.lo_z} = '0;
    {item_ch.hi_x, item_ch.hi_y, item_ch.hi_z} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
  end

  function automatic void model_reset();
    for (int i = 0; i < DIM*DIM; i++) model_mat[i] = '0;
    for (int i = 0; i < DIM; i++) model_mat[i*5] = word_t'(1 << FRAC);
    model_w = word_t'(1 << FRAC);
  endfunction

  function automatic word_t transformed_comp(word_t vx, word_t vy, word_t vz, int col);
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] sh;
    acc = '0;
    acc += SUM_W'(64'(vx) * 64'(model_mat[col]));
    acc += SUM_W'(64'(vy) * 64'(model_mat[4+col]));
    acc += SUM_W'(64'(vz) * 64'(model_mat[8+col]));
    acc += SUM_W'(64'(model_w) * 64'(model_mat[12+col]));
    sh = acc >>> FRAC;
    if (sh > 66'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (sh < -66'sh80000000) return 32'sh80000000;
    return word_t'(sh);
  endfunction

  function automatic bounds_t box_bounds(word_t lx, word_t ly, word_t lz,
                                         word_t hx, word_t hy, word_t hz);
    bounds_t b;
    word_t   lo [DIM];
    word_t   hi [DIM];
    word_t   t;
    for (int c = 0; c < 8; c++) begin
      for (int j = 0; j < DIM; j++) begin
        t = transformed_comp(c[2] ? hx : lx, c[1] ? hy : ly, c[0] ? hz : lz, j);
        if (c == 0 || t < lo[j]) lo[j] = t;
        if (c == 0 || t > hi[j]) hi[j] = t;
      end
    end
    b.lo_x = lo[0]; b.lo_y = lo[1]; b.lo_z = lo[2]; b.lo_w = lo[3];
    b.hi_x = hi[0]; b.hi_y = hi[1]; b.hi_z = hi[2]; b.hi_w = hi[3];
    return b;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return word_t'($urandom_range(0, 8) << FRAC) * ($urandom_range(0, 1) ? 1 : -1);
      3, 4: return word_t'($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
      default: return word_t'($urandom);
    endcase
  endfunction

  // valid stays high between back-to-back words; drain() drops it
  task automatic send_word(logic mode, logic [1:0] row, word_t c0, word_t c1, word_t c2,
                           word_t c3, word_t lx, word_t ly, word_t lz,
                           word_t hx, word_t hy, word_t hz);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.mode <= mode;
    item_ch.row_index <= row;
    item_ch.row_col0 <= c0; item_ch.row_col1 <= c1;
    item_ch.row_col2 <= c2; item_ch.row_col3 <= c3;
    item_ch.lo_x <= lx; item_ch.lo_y <= ly; item_ch.lo_z <= lz;
    item_ch.hi_x <= hx; item_ch.hi_y <= hy; item_ch.hi_z <= hz;
    do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
    if (mode == MODE_LOAD) begin
      model_mat[row*4]   = c0; model_mat[row*4+1] = c1;
      model_mat[row*4+2] = c2; model_mat[row*4+3] = c3;
      load_count++;
    end else begin
      bounds_q.push_back(box_bounds(lx, ly, lz, hx, hy, hz));
      box_count++;
    end
  endtask

  task automatic send_load(logic [1:0] row, word_t c0, word_t c1, word_t c2, word_t c3);
    send_word(MODE_LOAD, row, c0, c1, c2, c3, rand_word(), rand_word(), rand_word(),
              rand_word(), rand_word(), rand_word());
  endtask

  task automatic send_box(word_t lx, word_t ly, word_t lz, word_t hx, word_t hy, word_t hz);
    send_word(MODE_BOX, 2'($urandom), rand_word(), rand_word(), rand_word(), rand_word(),
              lx, ly, lz, hx, hy, hz);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    while (bounds_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_corner_w(word_t w);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= w;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    model_w = w;
  endtask

  task automatic test_identity_and_extremes();
    send_box(32'sh00010000, 32'sh00020000, 32'sh00030000,
             32'sh00040000, 32'sh00050000, 32'sh00060000);
    send_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
             32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_box(32'sh00050000, 32'shFFFF0000, 32'sh7FFFFFFF,
             32'shFFFB0000, 32'sh00030000, 32'sh80000000);
    send_box('0, '0, '0, '0, '0, '0);
  endtask

  task automatic test_matrix_saturation();
    for (int r = 0; r < DIM; r++)
      send_load(2'(r), 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    send_box(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
             32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_box(32'sh00000001, 32'shFFFFFFFF, '0, 32'sh00000002, 32'shFFFFFFFE, '0);
    send_load(2'd0, 32'sh00008000, 32'shFFFF8000, '0, 32'sh00010000);
    send_load(2'd1, '0, 32'sh00020000, 32'sh00000001, '0);
    send_load(2'd2, 32'shFFFFFFFF, '0, 32'sh00010000, '0);
    send_load(2'd3, 32'sh00100000, 32'shFFF00000, '0, 32'sh00010000);
    send_box(32'shFFFFFFFF, 32'sh00000003, 32'shFFFFFFFD,
             32'sh00000001, 32'shFFFFFFF0, 32'sh00000007);
    send_box(32'sh12345678, 32'shDEADBEEF, 32'sh0000FFFF,
             32'shEDCBA987, 32'sh21524111, 32'shFFFF0001);
    drain();
  endtask

  task automatic test_corner_w();
    word_t ws [5] = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh00000000,
                      32'shFFFF0000, 32'sh00010000};
    foreach (ws[k]) begin
      write_corner_w(ws[k]);
      send_box(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
      send_box(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
      drain();
    end
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 4; ph++) begin
      write_corner_w(ph == 3 ? 32'sh00010000 : rand_word());
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(0, 5) == 0)
          send_load(2'($urandom), rand_word(), rand_word(), rand_word(), rand_word());
        else
          send_box(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word());
      end
      drain();
    end
  endtask

  // result side: random back-pressure, compare against oldest expectation
  initial begin : result_side
    int stall;
    bounds_t e;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      got_count++;
      if (bounds_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result word at cycle %0d", cycle_count);
      end else begin
        e = bounds_q.pop_front();
        if (res_ch.out_lo_x !== e.lo_x || res_ch.out_lo_y !== e.lo_y ||
            res_ch.out_lo_z !== e.lo_z || res_ch.out_lo_w !== e.lo_w ||
            res_ch.out_hi_x !== e.hi_x || res_ch.out_hi_y !== e.hi_y ||
            res_ch.out_hi_z !== e.hi_z || res_ch.out_hi_w !== e.hi_w) begin
          err_count++;
          if (err_count <= 10) begin
            $display("mismatch word %0d lo exp %h %h %h %h got %h %h %h %h", got_count,
                     e.lo_x, e.lo_y, e.lo_z, e.lo_w, res_ch.out_lo_x, res_ch.out_lo_y,
                     res_ch.out_lo_z, res_ch.out_lo_w);
            $display("  hi exp %h %h %h %h got %h %h %h %h", e.hi_x, e.hi_y, e.hi_z,
                     e.hi_w, res_ch.out_hi_x, res_ch.out_hi_y, res_ch.out_hi_z,
                     res_ch.out_hi_w);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity_and_extremes();
    test_matrix_saturation();
    test_corner_w();
    test_random_traffic();
    drain();
    if (bounds_q.size() != 0) err_count++;
    $display("%0d box words and %0d row loads sent, %0d results checked, %0d errors",
             box_count, load_count, got_count, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
